// ===== rtl/esra_pkg.sv =====
// Package for the exact-size reuse allocator: sizes, widths, register indexes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package esra_pkg;

  localparam int ARENA_BYTES = 65536;
  localparam int FREE_DEPTH  = 64;
  localparam int HDR_BYTES   = 64;

  localparam int ALIGN_W    = $clog2(HDR_BYTES);
  localparam int SLOT_COUNT = ARENA_BYTES / HDR_BYTES;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CAP_W      = 17;
  localparam int SIZE_W     = 16;
  localparam int ADDR_W     = 32;
  localparam int IDX_W      = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
  localparam int ENTRY_W    = SLOT_W + SIZE_W;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARENA_BASE,
    REG_CAPACITY
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FREE_RD,
    ST_SEARCH,
    ST_SHIFT,
    ST_BUMP,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_TOP,
    IDX_DEC,
    IDX_INC
  } idx_op_t;

  typedef struct packed {
    logic    load_in;
    idx_op_t idx_op;
    logic    list_rd;
    logic    rd_plus1;
    logic    size_rd;
    logic    list_push;
    logic    shift_wr;
    logic    count_dec;
    logic    take_match;
    logic    bump_commit;
    logic    set_full;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic req_ok;
    logic addr_ok;
    logic list_empty;
    logic list_full;
    logic match;
    logic idx_zero;
    logic next_in_list;
    logic next2_in_list;
    logic bump_fit;
  } sts_t;

endpackage

// ===== rtl/esra_ctrl.sv =====
// Controller state machine of the exact-size reuse allocator.
// Drives datapath commands from its status; depends on esra_pkg.
module esra_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  esra_pkg::sts_t sts,
  output esra_pkg::cmd_t cmd
);
  import esra_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.idx_op = IDX_HOLD;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.is_free) begin
          if (!sts.addr_ok) begin
            state_nxt = ST_FINISH;
          end else if (sts.list_full) begin
            cmd.set_full = 1'b1;
            state_nxt    = ST_FINISH;
          end else begin
            cmd.size_rd = 1'b1;
            state_nxt   = ST_FREE_RD;
          end
        end else if (!sts.req_ok) begin
          state_nxt = ST_FINISH;
        end else if (sts.list_empty) begin
          state_nxt = ST_BUMP;
        end else begin
          cmd.idx_op  = IDX_TOP;
          cmd.list_rd = 1'b1;
          state_nxt   = ST_SEARCH;
        end
      end
      ST_FREE_RD: begin
        cmd.list_push = 1'b1;
        state_nxt     = ST_FINISH;
      end
      ST_SEARCH: begin
        if (sts.match) begin
          cmd.take_match = 1'b1;
          if (sts.next_in_list) begin
            cmd.list_rd  = 1'b1;
            cmd.rd_plus1 = 1'b1;
            state_nxt    = ST_SHIFT;
          end else begin
            cmd.count_dec = 1'b1;
            state_nxt     = ST_FINISH;
          end
        end else if (sts.idx_zero) begin
          state_nxt = ST_BUMP;
        end else begin
          cmd.idx_op  = IDX_DEC;
          cmd.list_rd = 1'b1;
        end
      end
      ST_SHIFT: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_op   = IDX_INC;
        if (sts.next2_in_list) begin
          cmd.list_rd  = 1'b1;
          cmd.rd_plus1 = 1'b1;
        end else begin
          cmd.count_dec = 1'b1;
          state_nxt     = ST_FINISH;
        end
      end
      ST_BUMP: begin
        cmd.bump_commit = sts.bump_fit;
        state_nxt       = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

endmodule

// ===== rtl/esra_datapath.sv =====
// Datapath of the exact-size reuse allocator: configuration, bump pointer,
// free-list memory, block-size memory, result and output registers. Depends on esra_pkg.
module esra_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [esra_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [esra_pkg::ADDR_W-1:0]          cfg_wdata,
  input  logic                                 in_func,
  input  logic [esra_pkg::ADDR_W-1:0]          in_request_size,
  input  logic [esra_pkg::ADDR_W-1:0]          in_block_address,
  output logic                                 out_ok,
  output logic [esra_pkg::ADDR_W-1:0]          out_payload_address,
  output logic                                 out_reused,
  output logic                                 out_list_full,
  output logic [esra_pkg::CAP_W-1:0]           out_used_bytes,
  input  esra_pkg::cmd_t                       cmd,
  output esra_pkg::sts_t                       sts
);
  import esra_pkg::*;

  localparam logic [CAP_W-1:0]  HDR_C = CAP_W'(HDR_BYTES);
  localparam logic [ADDR_W-1:0] HDR_A = ADDR_W'(HDR_BYTES);

  logic [ADDR_W-1:0]  base_r;
  logic [CAP_W-1:0]   capacity_r;
  logic [CAP_W-1:0]   used_r;
  logic [CNT_W-1:0]   count_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  logic               func_r;
  logic [ADDR_W-1:0]  req_r;
  logic [ADDR_W-1:0]  addr_r;

  logic               res_ok_r, res_reused_r, res_full_r;
  logic [ADDR_W-1:0]  res_payload_r;

  logic [ENTRY_W-1:0] list_mem [FREE_DEPTH];
  logic [ENTRY_W-1:0] list_q_r;
  logic [SIZE_W-1:0]  size_mem [SLOT_COUNT];
  logic [SIZE_W-1:0]  size_q_r;

  logic [CAP_W-1:0]   cap_eff;
  logic [CAP_W:0]     rsize_sum;
  logic [CAP_W-1:0]   rsize;
  logic [CAP_W-1:0]   room;
  logic [ADDR_W-1:0]  off;
  logic [ADDR_W-1:0]  hdr;
  logic [SLOT_W-1:0]  free_slot;
  logic [SLOT_W-1:0]  bump_slot;
  logic [SLOT_W-1:0]  rd_slot;
  logic [SIZE_W-1:0]  rd_size;
  logic [IDX_W-1:0]   list_rd_addr;
  logic [IDX_W-1:0]   list_wr_addr;
  logic [ENTRY_W-1:0] list_wr_data;
  logic [CNT_W:0]     idx_ext;

  // Capacity above the arena acts as the arena size
  assign cap_eff = (capacity_r > CAP_W'(ARENA_BYTES)) ? CAP_W'(ARENA_BYTES) : capacity_r;

  // Round up to the header granule; only meaningful when the request fits the capacity
  assign rsize_sum = {1'b0, req_r[CAP_W-1:0]} + (CAP_W + 1)'(HDR_BYTES - 1);
  assign rsize     = {rsize_sum[CAP_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
  assign room      = cap_eff - used_r;

  assign off       = addr_r - base_r;
  assign hdr       = off - HDR_A;
  assign free_slot = hdr[SLOT_W+ALIGN_W-1:ALIGN_W];
  assign bump_slot = used_r[SLOT_W+ALIGN_W-1:ALIGN_W];

  assign rd_slot = list_q_r[ENTRY_W-1:SIZE_W];
  assign rd_size = list_q_r[SIZE_W-1:0];
  assign idx_ext = (CNT_W + 1)'(idx_r);

  always_comb begin
    sts.is_free       = func_r;
    sts.req_ok        = req_r <= ADDR_W'(cap_eff);
    sts.addr_ok       = (addr_r != '0) && (off >= HDR_A) &&
                        (hdr[ALIGN_W-1:0] == '0) && (hdr < ADDR_W'(cap_eff));
    sts.list_empty    = count_r == '0;
    sts.list_full     = count_r >= CNT_W'(FREE_DEPTH);
    sts.match         = CAP_W'(rd_size) == rsize;
    sts.idx_zero      = idx_r == '0;
    sts.next_in_list  = (idx_ext + (CNT_W + 1)'(1)) < (CNT_W + 1)'(count_r);
    sts.next2_in_list = (idx_ext + (CNT_W + 1)'(2)) < (CNT_W + 1)'(count_r);
    sts.bump_fit      = (room >= HDR_C) && (rsize <= room - HDR_C);
  end

  always_comb begin
    case (cmd.idx_op)
      IDX_HOLD: idx_nxt = idx_r;
      IDX_TOP:  idx_nxt = IDX_W'(count_r - CNT_W'(1));
      IDX_DEC:  idx_nxt = idx_r - IDX_W'(1);
      IDX_INC:  idx_nxt = idx_r + IDX_W'(1);
      default:  idx_nxt = idx_r;
    endcase
  end

  assign list_rd_addr = cmd.rd_plus1 ? (idx_nxt + IDX_W'(1)) : idx_nxt;
  assign list_wr_addr = cmd.list_push ? count_r[IDX_W-1:0] : idx_r;
  assign list_wr_data = cmd.list_push ? {free_slot, size_q_r} : list_q_r;

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      capacity_r <= CAP_W'(ARENA_BYTES);
      used_r     <= '0;
      count_r    <= '0;
      idx_r      <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ARENA_BASE: base_r <= cfg_wdata;
          REG_CAPACITY: begin
            capacity_r <= cfg_wdata[CAP_W-1:0];
            used_r     <= '0;
            count_r    <= '0;
          end
          default: ;
        endcase
      end else begin
        if (cmd.bump_commit) used_r <= used_r + HDR_C + rsize;
        if (cmd.list_push) begin
          count_r <= count_r + CNT_W'(1);
        end else if (cmd.count_dec) begin
          count_r <= count_r - CNT_W'(1);
        end
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r        <= in_func;
      req_r         <= in_request_size;
      addr_r        <= in_block_address;
      res_ok_r      <= 1'b0;
      res_reused_r  <= 1'b0;
      res_full_r    <= 1'b0;
      res_payload_r <= '0;
    end
    if (cmd.take_match) begin
      res_ok_r      <= 1'b1;
      res_reused_r  <= 1'b1;
      res_payload_r <= base_r + ADDR_W'({rd_slot, {ALIGN_W{1'b0}}}) + HDR_A;
    end
    if (cmd.bump_commit) begin
      res_ok_r      <= 1'b1;
      res_payload_r <= base_r + ADDR_W'(used_r) + HDR_A;
    end
    if (cmd.list_push) res_ok_r <= 1'b1;
    if (cmd.set_full)  res_full_r <= 1'b1;
    if (cmd.out_load) begin
      out_ok              <= res_ok_r;
      out_payload_address <= res_payload_r;
      out_reused          <= res_reused_r;
      out_list_full       <= res_full_r;
      out_used_bytes      <= used_r;
    end
  end

  // Free list memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.list_push || cmd.shift_wr) list_mem[list_wr_addr] <= list_wr_data;
    if (cmd.list_rd) list_q_r <= list_mem[list_rd_addr];
  end

  // Block size memory, indexed by header slot
  always_ff @(posedge clk) begin
    if (cmd.bump_commit) size_mem[bump_slot] <= rsize[SIZE_W-1:0];
    if (cmd.size_rd) size_q_r <= size_mem[free_slot];
  end

endmodule

// ===== rtl/exact_size_reuse_allocator.sv =====
// Exact-size reuse allocator: top level joining controller and datapath; depends on esra_pkg.
// An oversized request, an ignored free or a free dropped by a full list finishes after the check;
//   a pushed free reads the block size, then pushes; an allocation with an empty free list bumps;
//   a search walks n entries newest first; no match bumps, a reuse at the n-th compacts n - 1.
// Requests are taken one at a time, once the sequential free-list walk of the last one is done.
// Reset: synchronous active-low; clears bump pointer, free count and state, base 0, capacity 65536.
module exact_size_reuse_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [esra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [esra_pkg::ADDR_W-1:0]    cfg_wdata,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [esra_pkg::ADDR_W-1:0]    in_request_size,
  input  logic [esra_pkg::ADDR_W-1:0]    in_block_address,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_ok,
  output logic [esra_pkg::ADDR_W-1:0]    out_payload_address,
  output logic                           out_reused,
  output logic                           out_list_full,
  output logic [esra_pkg::CAP_W-1:0]     out_used_bytes
);
  import esra_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each request: check, walk the free list newest first, compact on reuse,
  // otherwise bump; hand the result to the output register, which frees the
  // controller to take the next request while the result waits.
  esra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold configuration, bump pointer, free list and block sizes; compute
  // rounding, fit and address checks for the controller.
  esra_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_func             (in_func),
    .in_request_size     (in_request_size),
    .in_block_address    (in_block_address),
    .out_ok              (out_ok),
    .out_payload_address (out_payload_address),
    .out_reused          (out_reused),
    .out_list_full       (out_list_full),
    .out_used_bytes      (out_used_bytes),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule
